@@ sv/polyphonic_envelope_generator_unit_macros.svh @@
// Assertion macros for the envelope generator.
// Used by the controller and the top level.
`ifndef POLYPHONIC_ENVELOPE_GENERATOR_UNIT_MACROS_SVH
`define POLYPHONIC_ENVELOPE_GENERATOR_UNIT_MACROS_SVH
// assert that a implies b in the same cycle
`define PEG_ASSERT_IMP(label, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("%m: check failed");
// assert that a implies b in the next cycle
`define PEG_ASSERT_NXT(label, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("%m: check failed");
`endif

@@ sv/peg_pkg.sv @@
// Package for the polyphonic envelope generator: payload structs, stage codes,
// widths and defaults. No dependencies.
`default_nettype none
package peg_pkg;
  localparam int VOICES_DEF    = 16;
  localparam int IS_AMP_DEF    = 1;
  localparam int CHANNELS_DEF  = 2;
  localparam int FRAC_BITS_DEF = 24;

  localparam logic [2:0] ST_NONE    = 3'd0;
  localparam logic [2:0] ST_DELAY   = 3'd1;
  localparam logic [2:0] ST_ATTACK  = 3'd2;
  localparam logic [2:0] ST_DECAY   = 3'd3;
  localparam logic [2:0] ST_SUSTAIN = 3'd4;
  localparam logic [2:0] ST_RELEASE = 3'd5;

  localparam logic [1:0] VS_IDLE = 2'd0;
  localparam logic [1:0] VS_ON   = 2'd1;
  localparam logic [1:0] VS_STOP = 2'd2;

  localparam logic [2:0] REG_DELAY_TIME    = 3'd0;
  localparam logic [2:0] REG_START_LEVEL   = 3'd1;
  localparam logic [2:0] REG_ATTACK_TIME   = 3'd2;
  localparam logic [2:0] REG_DECAY_TIME    = 3'd3;
  localparam logic [2:0] REG_DECAY_LEVEL   = 3'd4;
  localparam logic [2:0] REG_SUSTAIN_TIME  = 3'd5;
  localparam logic [2:0] REG_SUSTAIN_LEVEL = 3'd6;
  localparam logic [2:0] REG_RELEASE_TIME  = 3'd7;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 24;

  typedef struct packed {
    logic [3:0]         voice_index;
    logic [1:0]         voice_state;
    logic [31:0]        voice_time;
    logic [16:0]        output_gain;
    logic signed [23:0] sample_in_left;
    logic signed [23:0] sample_in_right;
  } in_word_t;

  typedef struct packed {
    logic signed [17:0] envelope_out;
    logic signed [23:0] sample_out_left;
    logic signed [23:0] sample_out_right;
    logic               request_stopping;
    logic               voice_finished;
  } out_word_t;

  // controller to datapath
  typedef struct packed {
    logic load;       // latch input word, read voice state
    logic eval;       // run stage logic, may start a divide
    logic div_step;   // one restoring divide step
    logic commit;     // write back voice state
    logic mul_env;    // gain * value
    logic mul_smp;    // sample scaling
  } peg_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_div;
    logic div_last;
  } peg_sts_t;
endpackage
`default_nettype wire

@@ sv/polyphonic_envelope_generator_unit.sv @@
// Polyphonic envelope generator, one word per voice sample tick.
// Each word is loaded, evaluated, written back and scaled; when a slope
// is divided (restoring divider, one quotient bit per cycle) the divide runs
// between evaluation and write-back. One word at a time; a stalled
// output holds the sequencer until the output register frees.
// Reset: synchronous active-low; all voices go to no stage, registers to defaults.
`default_nettype none
`include "polyphonic_envelope_generator_unit_macros.svh"
module polyphonic_envelope_generator_unit
  import peg_pkg::*;
#(
  parameter int VOICES    = VOICES_DEF,
  parameter int IS_AMP    = IS_AMP_DEF,
  parameter int CHANNELS  = CHANNELS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire in_word_t              in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output out_word_t                  out_data,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);
  peg_cmd_t  cmd;
  peg_sts_t  sts;
  out_word_t res_word;
  logic      res_valid;
  logic      out_valid_r;

  peg_ctrl u_ctrl (
    .clk, .rst_n,
    .in_fire  (in_valid && in_ready),
    .out_busy (out_valid_r && !out_ready),
    .sts, .cmd, .in_ready, .res_valid
  );

  peg_dp #(
    .VOICES(VOICES), .IS_AMP(IS_AMP), .CHANNELS(CHANNELS), .FRAC_BITS(FRAC_BITS)
  ) u_dp (
    .clk, .rst_n, .cmd, .in_word(in_data),
    .cfg_we, .cfg_index, .cfg_data, .sts, .res_word
  );

  // output register holds the word until taken
  always_ff @(posedge clk) begin
    if (!rst_n)                  out_valid_r <= 1'b0;
    else if (res_valid)          out_valid_r <= 1'b1;
    else if (out_ready)          out_valid_r <= 1'b0;
  end
  always_ff @(posedge clk) begin
    if (res_valid) out_data <= res_word;
  end
  assign out_valid = out_valid_r;

  `PEG_ASSERT_IMP(a_no_overwrite, res_valid, !(out_valid_r && !out_ready))
  `PEG_ASSERT_NXT(a_res_shows, res_valid, out_valid)
  `PEG_ASSERT_IMP(a_no_accept_busy, in_ready, !res_valid)
endmodule
`default_nettype wire

@@ sv/peg_ctrl.sv @@
// Sequencer for the envelope generator: steps one word through load, stage
// evaluation, an optional iterative divide, write-back and output scaling.
// Depends on peg_pkg.
`default_nettype none
`include "polyphonic_envelope_generator_unit_macros.svh"
module peg_ctrl
  import peg_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_fire,
  input  wire logic     out_busy,
  input  wire peg_sts_t sts,
  output peg_cmd_t      cmd,
  output logic          in_ready,
  output logic          res_valid
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EVAL = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_MUL1 = 3'd3;
  localparam logic [2:0] S_MUL2 = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    res_valid = 1'b0;
    in_ready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_fire) begin
          cmd.load = 1'b1;
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.eval = 1'b1;
        state_nxt = sts.need_div ? S_DIV : S_MUL1;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_nxt = S_MUL1;
      end
      S_MUL1: begin
        cmd.commit = 1'b1;
        cmd.mul_env = 1'b1;
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul_smp = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        // hand the word to the output register when it is free
        if (!out_busy) begin
          res_valid = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  `PEG_ASSERT_NXT(a_load_eval, cmd.load, state_r == S_EVAL)
  `PEG_ASSERT_IMP(a_ready_idle, in_ready, state_r == S_IDLE)
  `PEG_ASSERT_NXT(a_commit_once, cmd.commit, !cmd.commit)
endmodule
`default_nettype wire

@@ sv/peg_dp.sv @@
// Datapath of the envelope generator: per-voice state, stage arithmetic,
// restoring divider and output multipliers. Depends on peg_pkg.
`default_nettype none
module peg_dp
  import peg_pkg::*;
#(
  parameter int VOICES    = VOICES_DEF,
  parameter int IS_AMP    = IS_AMP_DEF,
  parameter int CHANNELS  = CHANNELS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire peg_cmd_t              cmd,
  input  wire in_word_t              in_word,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output peg_sts_t                   sts,
  output out_word_t                  res_word
);
  localparam int EW = FRAC_BITS + 3;
  localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int NW = EW + 1;          // dividend magnitude width
  localparam int CW = $clog2(NW + 1);
  localparam int SH = FRAC_BITS - 16;
  localparam logic signed [EW-1:0] ENV_ONE = EW'(1) <<< FRAC_BITS;
  localparam logic signed [EW-1:0] ENV_MAX = {1'b0, {(EW-1){1'b1}}};
  localparam logic signed [EW-1:0] ENV_MIN = {1'b1, {(EW-1){1'b0}}};

  // configuration
  logic [23:0] delay_time_r, attack_time_r, decay_time_r, sustain_time_r, release_time_r;
  logic [17:0] start_level_r;
  logic [16:0] decay_level_r, sustain_level_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_time_r    <= '0;
      start_level_r   <= '0;
      attack_time_r   <= 24'd4800;
      decay_time_r    <= 24'd4800;
      decay_level_r   <= 17'd65536;
      sustain_time_r  <= 24'd4800;
      sustain_level_r <= 17'd65536;
      release_time_r  <= 24'd4800;
    end else if (cfg_we && cfg_index[CFG_IDX_W-1:3] == '0) begin
      case (cfg_index[2:0])
        REG_DELAY_TIME:    delay_time_r    <= cfg_data;
        REG_START_LEVEL:   start_level_r   <= cfg_data[17:0];
        REG_ATTACK_TIME:   attack_time_r   <= cfg_data;
        REG_DECAY_TIME:    decay_time_r    <= cfg_data;
        REG_DECAY_LEVEL:   decay_level_r   <= cfg_data[16:0];
        REG_SUSTAIN_TIME:  sustain_time_r  <= cfg_data;
        REG_SUSTAIN_LEVEL: sustain_level_r <= cfg_data[16:0];
        REG_RELEASE_TIME:  release_time_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // per-voice state: VOICES entries each of stage, value and step, read on load
  logic [2:0]          stage_r [VOICES];
  logic signed [EW-1:0] val_r  [VOICES];
  logic signed [EW-1:0] stp_r  [VOICES];

  in_word_t            w_r;
  logic                ok_r;
  logic [VW-1:0]       vi_r;
  logic [2:0]          s_r;
  logic signed [EW-1:0] v_r, p_r;
  logic                req_r, fin_r;
  // divide bookkeeping
  logic                div_neg_r, div_sat_r;
  logic [NW-1:0]       dq_r;     // dividend shifting into quotient
  logic [24:0]         drem_r;
  logic [23:0]         dden_r;
  logic [CW-1:0]       dcnt_r;

  wire logic signed [EW-1:0] start_e = EW'(signed'(start_level_r)) <<< SH;
  wire logic signed [EW-1:0] dlev_e  = EW'(signed'({1'b0, decay_level_r})) <<< SH;
  wire logic signed [EW-1:0] slev_e  = EW'(signed'({1'b0, sustain_level_r})) <<< SH;

  function automatic logic signed [EW-1:0] sat_e(input logic signed [EW:0] x);
    if (x > (EW+1)'(ENV_MAX)) return ENV_MAX;
    if (x < (EW+1)'(ENV_MIN)) return ENV_MIN;
    return x[EW-1:0];
  endfunction

  // stage evaluation
  logic [2:0]          e_s;
  logic signed [EW-1:0] e_v, e_p;
  logic                e_req, e_fin, e_div;
  logic signed [EW:0]  e_num;
  logic [23:0]         e_den;
  logic                e_sat;
  logic [2:0]          go;
  localparam logic [2:0] GO_NONE = 3'd0, GO_DECAY = 3'd1, GO_SUST = 3'd2,
                         GO_PREP = 3'd3, GO_RUN = 3'd4;

  always_comb begin
    e_s = s_r; e_v = v_r; e_p = p_r; e_req = 1'b0; e_fin = 1'b0;
    e_div = 1'b0; e_num = '0; e_den = '0; e_sat = 1'b0; go = GO_NONE;
    if (ok_r && w_r.voice_state == VS_ON) begin
      if (e_s == ST_NONE && w_r.voice_time == '0) e_s = ST_DELAY;
      case (e_s)
        ST_NONE: ;
        ST_DELAY: begin
          e_v = start_e;
          if (w_r.voice_time >= {8'd0, delay_time_r}) begin
            if (attack_time_r != '0) begin
              e_s = ST_ATTACK; e_div = 1'b1; e_sat = 1'b1;
              e_num = (EW+1)'(ENV_ONE) - (EW+1)'(start_e); e_den = attack_time_r;
            end else go = GO_DECAY;
          end
        end
        ST_ATTACK: begin
          e_v = sat_e((EW+1)'(v_r) + (EW+1)'(p_r));
          if (e_v >= ENV_ONE) go = GO_DECAY;
        end
        ST_DECAY: begin
          e_v = sat_e((EW+1)'(v_r) - (EW+1)'(p_r));
          if (e_v <= dlev_e) go = GO_SUST;
        end
        ST_SUSTAIN: begin
          if (v_r > slev_e) begin
            e_v = sat_e((EW+1)'(v_r) - (EW+1)'(p_r));
            if (e_v < slev_e) e_v = slev_e;
          end else if (v_r < slev_e) begin
            e_v = sat_e((EW+1)'(v_r) + (EW+1)'(p_r));
            if (e_v > slev_e) e_v = slev_e;
          end
        end
        default: go = GO_RUN;
      endcase
      if (go == GO_DECAY) begin
        if (decay_time_r != '0) begin
          e_v = ENV_ONE; e_s = ST_DECAY; e_div = 1'b1; e_sat = 1'b1;
          e_num = (EW+1)'(ENV_ONE) - (EW+1)'(dlev_e); e_den = decay_time_r;
        end else go = GO_SUST;
      end
      if (go == GO_SUST) begin
        if (sustain_time_r != '0) begin
          e_s = ST_SUSTAIN; e_div = 1'b1; e_sat = 1'b1;
          e_num = (e_v > slev_e) ? (EW+1)'(e_v) - (EW+1)'(slev_e)
                                 : (EW+1)'(slev_e) - (EW+1)'(e_v);
          e_den = sustain_time_r;
        end else begin
          e_req = (IS_AMP != 0); go = GO_PREP;
        end
      end
    end else if (ok_r && w_r.voice_state == VS_STOP) begin
      go = (s_r == ST_RELEASE) ? GO_RUN : GO_PREP;
    end
    if (go == GO_PREP) begin
      e_s = ST_RELEASE;
      if (release_time_r != '0) begin
        e_div = 1'b1; e_num = (EW+1)'(e_v); e_den = release_time_r;
      end else e_p = e_v;
    end else if (go == GO_RUN) begin
      e_v = sat_e((EW+1)'(v_r) - (EW+1)'(p_r));
      if (e_v <= 0 || p_r == 0) begin
        e_s = ST_NONE; e_v = '0; e_p = '0; e_fin = 1'b1;
      end
    end
  end

  assign sts.need_div = e_div;
  assign sts.div_last = (dcnt_r == CW'(1));

  // one restoring step: shift in next dividend bit
  wire logic [24:0] d_trial = {drem_r[23:0], dq_r[NW-1]};
  wire logic        d_ge    = d_trial >= {1'b0, dden_r};
  wire logic [24:0] d_rem_n = d_ge ? d_trial - {1'b0, dden_r} : d_trial;

  // quotient after the final step, with sign and saturation
  function automatic logic signed [EW-1:0] q_res_next();
    logic [NW-1:0] q;
    logic signed [NW:0] qs;
    q = {dq_r[NW-2:0], d_ge};
    qs = div_neg_r ? -(NW+1)'(q) : (NW+1)'(q);
    if (div_sat_r) return sat_e(qs[EW:0]);
    return qs[EW-1:0];
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [41:0] x);
    if (x > 42'sd8388607)  return 24'sh7FFFFF;
    if (x < -42'sd8388608) return 24'sh800000;
    return x[23:0];
  endfunction

  logic signed [EW+17:0] m_env_r;
  logic signed [41:0]    m_l, m_r;

  // envelope: floor shift, clamp to +-1.0
  logic signed [EW+17:0] env_sh;
  logic signed [17:0]    env_c;
  always_comb begin
    env_sh = m_env_r >>> FRAC_BITS;
    if (env_sh > (EW+18)'(65536))       env_c = 18'sd65536;
    else if (env_sh < -(EW+18)'(65536)) env_c = -18'sd65536;
    else                                env_c = env_sh[17:0];
  end
  assign m_l = 42'(w_r.sample_in_left) * 42'(env_c);
  assign m_r = 42'(w_r.sample_in_right) * 42'(env_c);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      w_r  <= in_word;
      ok_r <= 32'(in_word.voice_index) < VOICES;
      vi_r <= VW'(in_word.voice_index);
      if (32'(in_word.voice_index) < VOICES) begin
        s_r <= stage_r[VW'(in_word.voice_index)];
        v_r <= val_r[VW'(in_word.voice_index)];
        p_r <= stp_r[VW'(in_word.voice_index)];
      end else begin
        s_r <= ST_NONE; v_r <= '0; p_r <= '0;
      end
    end
    if (cmd.eval) begin
      s_r <= e_s; v_r <= e_v; p_r <= e_p;
      req_r <= e_req; fin_r <= e_fin;
      div_neg_r <= e_num[EW];
      div_sat_r <= e_sat;
      dq_r   <= e_num[EW] ? NW'(-e_num) : NW'(e_num);
      drem_r <= '0;
      dden_r <= e_den;
      dcnt_r <= CW'(NW);
    end
    if (cmd.div_step) begin
      drem_r <= d_rem_n;
      dq_r   <= {dq_r[NW-2:0], d_ge};
      dcnt_r <= dcnt_r - CW'(1);
      if (dcnt_r == CW'(1)) p_r <= q_res_next();
    end
    if (cmd.mul_env) begin
      // value is already zero for a voice index out of range
      m_env_r <= (EW+18)'(signed'({1'b0, w_r.output_gain})) * (EW+18)'(v_r);
    end
    if (cmd.mul_smp) begin
      res_word.envelope_out     <= env_c;
      res_word.sample_out_left  <= (IS_AMP != 0) ? sat24(m_l >>> 16) : w_r.sample_in_left;
      res_word.sample_out_right <= (CHANNELS < 2) ? '0 :
                                   (IS_AMP != 0) ? sat24(m_r >>> 16) : w_r.sample_in_right;
      res_word.request_stopping <= req_r;
      res_word.voice_finished   <= fin_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < VOICES; i++) begin
        stage_r[i] <= ST_NONE; val_r[i] <= '0; stp_r[i] <= '0;
      end
    end else if (cmd.commit && ok_r) begin
      stage_r[vi_r] <= s_r; val_r[vi_r] <= v_r; stp_r[vi_r] <= p_r;
    end
  end
endmodule
`default_nettype wire
